FILE: hw/rtl/fra_pkg.sv
package fra_pkg;

  // Field widths and fixed-point format
  localparam int IN_W      = 32;
  localparam int FRAC_BITS = 16;
  localparam int DEN_BITS  = 16;
  localparam int NUM_W     = DEN_BITS + 1;
  // walk terms reach twice the largest denominator
  localparam int WK_W      = DEN_BITS + 1;
  // cross products: target term times a walk denominator sum
  localparam int PROD_W    = IN_W + DEN_BITS + 2;

  localparam logic [IN_W-1:0] ONE_FIXED = IN_W'(64'd1 << FRAC_BITS);

  // Configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [CFG_AW-3:0] REG_MAX_DEN = '0;
  localparam logic [DEN_BITS-1:0] MAX_DEN_RESET = DEN_BITS'(1024);

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } fra_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic finish;
  } fra_sts_t;

endpackage

FILE: hw/rtl/fra_cfg.sv
module fra_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fra_pkg::CFG_AW-1:0]    paddr,
  input  logic [fra_pkg::CFG_DW-1:0]    pwdata,
  output logic [fra_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  output logic [fra_pkg::DEN_BITS-1:0]  max_den
);
  import fra_pkg::*;

  logic [DEN_BITS-1:0] max_den_r, max_den_nxt;
  logic                hit;

  assign pready = 1'b1;
  assign hit    = (paddr[CFG_AW-1:2] == REG_MAX_DEN);

  // register write in the access phase
  always_comb begin
    max_den_nxt = max_den_r;
    if (psel && penable && pwrite && hit) begin
      max_den_nxt = pwdata[DEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_den_r <= MAX_DEN_RESET;
    end else begin
      max_den_r <= max_den_nxt;
    end
  end

  // read back
  assign prdata  = hit ? CFG_DW'(max_den_r) : '0;
  assign max_den = max_den_r;

endmodule

FILE: hw/rtl/fra_dp.sv
module fra_dp (
  input  logic                                clk,
  input  fra_pkg::fra_cmd_t                   cmd,
  output fra_pkg::fra_sts_t                   sts,
  input  logic [fra_pkg::DEN_BITS-1:0]        lim,
  input  logic signed [fra_pkg::IN_W-1:0]     in_value,
  output logic signed [fra_pkg::NUM_W-1:0]    res_num,
  output logic [fra_pkg::DEN_BITS-1:0]        res_den
);
  import fra_pkg::*;

  // item flags
  logic neg_r, neg_nxt;
  logic rcp_r, rcp_nxt;
  // bounds lo = lo_n/lo_d, hi = hi_n/hi_d
  logic [WK_W-1:0] lo_n_r, lo_n_nxt, lo_d_r, lo_d_nxt;
  logic [WK_W-1:0] hi_n_r, hi_n_nxt, hi_d_r, hi_d_nxt;
  // running cross products: tn*lo_d, lo_n*td, tn*hi_d, hi_n*td
  logic [PROD_W-1:0] llo_r, llo_nxt, rlo_r, rlo_nxt;
  logic [PROD_W-1:0] lhi_r, lhi_nxt, rhi_r, rhi_nxt;
  // output register
  logic signed [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_BITS-1:0]     den_r, den_nxt;

  logic [IN_W-1:0]   mag, tn, td;
  logic              neg;
  logic [WK_W-1:0]   lim_x, mn, md, p, q, a, b;
  logic [PROD_W-1:0] lhs, rhs;
  logic              running, eq, gt;
  logic [NUM_W-1:0]  num_u;

  // sign and magnitude; the most negative input wraps to 2^31 unsigned
  assign neg = in_value[IN_W-1];
  assign mag = neg ? (~in_value + IN_W'(1)) : in_value;
  always_comb begin
    if (mag > ONE_FIXED) begin
      tn = ONE_FIXED;
      td = mag;
    end else begin
      tn = mag;
      td = ONE_FIXED;
    end
  end

  // mediant and its exact comparison with the target
  assign lim_x   = WK_W'(lim);
  assign mn      = lo_n_r + hi_n_r;
  assign md      = lo_d_r + hi_d_r;
  assign lhs     = llo_r + lhi_r;
  assign rhs     = rlo_r + rhi_r;
  assign running = (lo_d_r <= lim_x) && (hi_d_r <= lim_x);
  assign eq      = (lhs == rhs);
  assign gt      = (lhs > rhs);
  assign sts.finish = !running || eq;

  // answer pair once the walk has finished
  always_comb begin
    if (running) begin
      if (md <= lim_x) begin
        p = mn;
        q = md;
      end else if (hi_d_r > lo_d_r) begin
        p = hi_n_r;
        q = hi_d_r;
      end else begin
        p = lo_n_r;
        q = lo_d_r;
      end
    end else if (lo_d_r > lim_x) begin
      p = hi_n_r;
      q = hi_d_r;
    end else begin
      p = lo_n_r;
      q = lo_d_r;
    end
  end

  // swap for the reciprocal walk, then apply the sign
  assign a     = rcp_r ? q : p;
  assign b     = rcp_r ? p : q;
  assign num_u = NUM_W'(a);

  always_comb begin
    neg_nxt  = neg_r;
    rcp_nxt  = rcp_r;
    lo_n_nxt = lo_n_r;
    lo_d_nxt = lo_d_r;
    hi_n_nxt = hi_n_r;
    hi_d_nxt = hi_d_r;
    llo_nxt  = llo_r;
    rlo_nxt  = rlo_r;
    lhi_nxt  = lhi_r;
    rhi_nxt  = rhi_r;
    num_nxt  = num_r;
    den_nxt  = den_r;
    if (cmd.load) begin
      // start from 0/1 and 1/1
      neg_nxt  = neg;
      rcp_nxt  = (mag > ONE_FIXED);
      lo_n_nxt = '0;
      lo_d_nxt = WK_W'(1);
      hi_n_nxt = WK_W'(1);
      hi_d_nxt = WK_W'(1);
      llo_nxt  = PROD_W'(tn);
      rlo_nxt  = '0;
      lhi_nxt  = PROD_W'(tn);
      rhi_nxt  = PROD_W'(td);
    end else if (cmd.step) begin
      // mediant replaces one bound; its products are the sums
      if (gt) begin
        lo_n_nxt = mn;
        lo_d_nxt = md;
        llo_nxt  = lhs;
        rlo_nxt  = rhs;
      end else begin
        hi_n_nxt = mn;
        hi_d_nxt = md;
        lhi_nxt  = lhs;
        rhi_nxt  = rhs;
      end
    end
    if (cmd.emit) begin
      num_nxt = neg_r ? signed'(-num_u) : signed'(num_u);
      den_nxt = b[DEN_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    neg_r  <= neg_nxt;
    rcp_r  <= rcp_nxt;
    lo_n_r <= lo_n_nxt;
    lo_d_r <= lo_d_nxt;
    hi_n_r <= hi_n_nxt;
    hi_d_r <= hi_d_nxt;
    llo_r  <= llo_nxt;
    rlo_r  <= rlo_nxt;
    lhi_r  <= lhi_nxt;
    rhi_r  <= rhi_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
  end

  assign res_num = num_r;
  assign res_den = den_r;

endmodule

FILE: hw/rtl/fra_ctrl.sv
module fra_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fra_pkg::fra_cmd_t cmd,
  input  fra_pkg::fra_sts_t sts
);
  import fra_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_WALK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign in_ready  = (state_r == S_IDLE);
  assign slot_free = !out_valid_r || out_ready;

  // commands: load on accept, step until finished, emit when the slot frees
  always_comb begin
    cmd.load = in_valid && in_ready;
    cmd.step = (state_r == S_WALK) && !sts.finish;
    cmd.emit = (state_r == S_WALK) && sts.finish && slot_free;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (cmd.emit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    priority if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/farey_rational_approximation_unit.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid/in_ready     in_value_fixed (32, signed Q15.16)
// out      output     out_valid/out_ready   out_numerator (17, signed),
//                                            out_denominator (16)
// cfg      input      APB psel/penable      max_denominator at byte address 0
//
// One item at a time: the accept cycle loads the walk, then one mediant step
// per cycle, then the output register is written once the output slot frees.
// Steps never exceed max_denominator; the step loop, with its running cross
// products, sets how long an item takes.
// rst_n is synchronous; it clears control state and restores max_denominator.
// A waiting result holds the finished walk, and the next item is taken once
// the result has moved into the output register.
module farey_rational_approximation_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [fra_pkg::IN_W-1:0]    in_value_fixed,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fra_pkg::NUM_W-1:0]   out_numerator,
  output logic [fra_pkg::DEN_BITS-1:0]       out_denominator,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [fra_pkg::CFG_AW-1:0]         paddr,
  input  logic [fra_pkg::CFG_DW-1:0]         pwdata,
  output logic [fra_pkg::CFG_DW-1:0]         prdata,
  output logic                               pready
);
  import fra_pkg::*;

  fra_cmd_t            cmd;
  fra_sts_t            sts;
  logic [DEN_BITS-1:0] max_den;

  // configuration register
  fra_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_den (max_den)
  );

  // sequencer
  fra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // mediant walk
  fra_dp u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .sts      (sts),
    .lim      (max_den),
    .in_value (in_value_fixed),
    .res_num  (out_numerator),
    .res_den  (out_denominator)
  );

endmodule

FILE: bench/fra_checker.sv
module fra_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [fra_pkg::IN_W-1:0]     in_value_fixed,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [fra_pkg::NUM_W-1:0]    out_numerator,
  input  logic [fra_pkg::DEN_BITS-1:0]        out_denominator,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fra_pkg::CFG_AW-1:0]          paddr,
  input  logic [fra_pkg::CFG_DW-1:0]          pwdata,
  input  logic [fra_pkg::CFG_DW-1:0]          prdata,
  input  logic                                pready,
  output int                                  fail_count,
  output int                                  pending_count
);

  timeunit 1ns;
  timeprecision 1ps;

  import fra_pkg::*;

  typedef struct packed {
    logic signed [NUM_W-1:0] num;
    logic [DEN_BITS-1:0]     den;
  } ratio_t;

  localparam logic [63:0] ONE_WIDE = 64'd1 << FRAC_BITS;

  logic [DEN_BITS-1:0] max_den_copy;
  ratio_t              pending_ratios[$];

  // Stern-Brocot walk on |x| or its reciprocal, exact cross-multiplied compares
  function automatic ratio_t farey_approx(input logic [IN_W-1:0] v,
                                          input logic [DEN_BITS-1:0] lim);
    logic        neg, done, recip;
    logic [63:0] mag, tn, td, lim_w;
    logic [63:0] lo_n, lo_d, hi_n, hi_d, mn, md, lhs, rhs, p, q, num, den;
    ratio_t      r;
    neg   = v[IN_W-1];
    mag   = neg ? ((64'd1 << IN_W) - 64'(v)) : 64'(v);
    lim_w = 64'(lim);
    recip = (mag > ONE_WIDE);
    if (recip) begin
      tn = ONE_WIDE;
      td = mag;
    end else begin
      tn = mag;
      td = ONE_WIDE;
    end
    lo_n = 0; lo_d = 1; hi_n = 1; hi_d = 1;
    p = 0; q = 1;
    done = 1'b0;
    while (!done && lo_d <= lim_w && hi_d <= lim_w) begin
      mn  = lo_n + hi_n;
      md  = lo_d + hi_d;
      lhs = tn * md;
      rhs = mn * td;
      if (lhs == rhs) begin
        // exact hit on the mediant
        done = 1'b1;
        if (md <= lim_w) begin
          p = mn; q = md;
        end else if (hi_d > lo_d) begin
          p = hi_n; q = hi_d;
        end else begin
          p = lo_n; q = lo_d;
        end
      end else if (lhs > rhs) begin
        lo_n = mn; lo_d = md;
      end else begin
        hi_n = mn; hi_d = md;
      end
    end
    if (!done) begin
      if (lo_d > lim_w) begin
        p = hi_n; q = hi_d;
      end else begin
        p = lo_n; q = lo_d;
      end
    end
    // reciprocal path swaps the pair
    if (recip) begin
      num = q; den = p;
    end else begin
      num = p; den = q;
    end
    r.num = NUM_W'(neg ? (64'd0 - num) : num);
    r.den = DEN_BITS'(den);
    return r;
  endfunction

  always @(posedge clk) begin
    ratio_t want;
    if (!rst_n) begin
      max_den_copy = MAX_DEN_RESET;
      pending_ratios.delete();
    end else begin
      // track register writes, check read-back
      if (psel && penable && pready && paddr[CFG_AW-1:2] == REG_MAX_DEN) begin
        if (pwrite) begin
          max_den_copy = pwdata[DEN_BITS-1:0];
        end else if (prdata !== CFG_DW'(max_den_copy)) begin
          if (fail_count < 10)
            $display("max_denominator read: expected %0d got %0d", max_den_copy, prdata);
          fail_count++;
        end
      end
      // predict on every accepted item
      if (in_valid && in_ready)
        pending_ratios.push_back(farey_approx(in_value_fixed, max_den_copy));
      // compare every accepted result with the oldest prediction
      if (out_valid && out_ready) begin
        if (pending_ratios.size() == 0) begin
          if (fail_count < 10)
            $display("unexpected result: num %0d den %0d", out_numerator, out_denominator);
          fail_count++;
        end else begin
          want = pending_ratios.pop_front();
          if (want.num !== out_numerator || want.den !== out_denominator) begin
            if (fail_count < 10)
              $display("result mismatch: expected %0d/%0d got %0d/%0d",
                       want.num, want.den, out_numerator, out_denominator);
            fail_count++;
          end
        end
      end
    end
    pending_count <= pending_ratios.size();
  end

endmodule

FILE: bench/tb_farey_rational_approximation_unit.sv
module tb_farey_rational_approximation_unit;

  timeunit 1ns;
  timeprecision 1ps;

  import fra_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;
  localparam int HOLD_CYCLES    = 2000;
  localparam int FIRST_HOLD     = 300;
  localparam int LAST_HOLD      = 450;
  localparam logic [CFG_AW-1:0] ADDR_MAX_DEN = {REG_MAX_DEN, 2'b00};
  // next word up: no register there, writes must be dropped
  localparam logic [CFG_AW-1:0] ADDR_UNUSED  = ADDR_MAX_DEN + CFG_AW'(4);

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic signed [IN_W-1:0]   in_value_fixed;
  logic                     out_valid;
  logic                     out_ready;
  logic signed [NUM_W-1:0]  out_numerator;
  logic [DEN_BITS-1:0]      out_denominator;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_AW-1:0]        paddr;
  logic [CFG_DW-1:0]        pwdata;
  logic [CFG_DW-1:0]        prdata;
  logic                     pready;

  int fail_count;
  int pending_count;
  int n_sent = 0;
  int quiet_cycles = 0;
  bit sender_burst = 1'b0;

  farey_rational_approximation_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value_fixed  (in_value_fixed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_numerator   (out_numerator),
    .out_denominator (out_denominator),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  fra_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_value_fixed  (in_value_fixed),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_numerator   (out_numerator),
    .out_denominator (out_denominator),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .pending_count   (pending_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      return 0;
    else if (r < 85) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 15);
    else             return $urandom_range(40, 200);
  endfunction

  // bounded keeps |x| at most 64 and leaves out raw random words
  function automatic logic [IN_W-1:0] next_value(input bit bounded);
    int               r;
    logic [IN_W-1:0]  m;
    logic [IN_W-1:0]  v;
    r = bounded ? $urandom_range(25, 99) : $urandom_range(0, 99);
    if (r < 25) begin
      v = $urandom;
    end else begin
      if (r < 50)
        m = $urandom_range(0, 65536);
      else if (r < 70)
        m = $urandom_range(65537, bounded ? 32'h0040_0000 : 32'h7FFF_FFFF);
      else if (r < 80)
        m = IN_W'($urandom_range(1, 63)) << $urandom_range(0, 10);
      else if (r < 90)
        m = IN_W'($urandom_range(1, bounded ? 64 : 32767)) << FRAC_BITS;
      else begin
        case ($urandom_range(0, 5))
          0:       m = '0;
          1:       m = IN_W'(1);
          2:       m = ONE_FIXED;
          3:       m = ONE_FIXED + 1;
          4:       m = ONE_FIXED - 1;
          default: m = bounded ? (ONE_FIXED >> 1) : 32'h8000_0000;
        endcase
      end
      v = $urandom_range(0, 1) ? -m : m;
    end
    return v;
  endfunction

  // one item; valid stays high across back-to-back items
  task automatic send_value(input logic [IN_W-1:0] v);
    int gap;
    gap = sender_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value_fixed <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic run_random_items(input int count, input bit bounded);
    sender_burst = ($urandom_range(0, 3) == 0);
    repeat (count) send_value(next_value(bounded));
    sender_burst = 1'b0;
  endtask

  // stop offering and wait for every predicted result
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // setup, access, then idle with psel low before the next transfer
  task automatic cfg_access(input logic wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_max_den(input logic [CFG_DW-1:0] data);
    cfg_access(1'b1, ADDR_MAX_DEN, data);
    cfg_access(1'b0, ADDR_MAX_DEN, '0);
  endtask

  // result side: random back-pressure, free-running stretches, long hold-offs
  initial begin
    int  r;
    int  len;
    int  seg;
    int  next_hold;
    bit  level;
    bit  free_run;
    seg       = 0;
    next_hold = FIRST_HOLD;
    free_run  = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seg == 0) begin
        seg      = 64;
        free_run = ($urandom_range(0, 3) == 0);
      end
      seg--;
      r = $urandom_range(0, 99);
      if (n_sent >= next_hold && next_hold <= LAST_HOLD) begin
        // hold off while the sender keeps offering, so the input stalls
        next_hold += LAST_HOLD - FIRST_HOLD;
        level = 1'b0;
        len   = HOLD_CYCLES;
      end else if (free_run || r < 60) begin
        level = 1'b1;
        len   = $urandom_range(1, 8);
      end else if (r < 96) begin
        level = 1'b0;
        len   = $urandom_range(1, 4);
      end else begin
        level = 1'b0;
        len   = $urandom_range(30, 200);
      end
      out_ready <= level;
      repeat (len) @(posedge clk);
    end
  end

  // watchdog on cycles with no item moving on either channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_farey_rational_approximation_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [CFG_DW-1:0] data;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_value_fixed = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit: zero, ones, halves, near one, integers, extremes
    send_value(32'h0000_0000); send_value(32'h0000_0001);
    send_value(32'hFFFF_FFFF); send_value(32'h0000_8000);
    send_value(32'hFFFF_8000); send_value(32'h0000_FFFF);
    send_value(32'h0001_0000); send_value(32'hFFFF_0000);
    send_value(32'h0001_0001); send_value(32'h0001_8000);
    send_value(32'h0003_0000); send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000); send_value(32'h8000_0001);
    send_value(32'h5555_5555); send_value(32'hAAAA_AAAA);
    send_value(32'h0000_5555);
    // 1024.0 hits the limit exactly, 1025.0 lies beyond it
    send_value(32'h0400_0000); send_value(32'h0401_0000);
    wait_drained();

    // write to the unused word is dropped, then a zero limit
    cfg_access(1'b1, ADDR_UNUSED, 32'h0000_1234);
    set_max_den('0);
    send_value(32'h0000_0000); send_value(32'h0001_0000);
    send_value(32'hFFFF_0000); send_value(32'h8000_0000);
    send_value(32'h0000_4000);
    run_random_items(15, 1'b0);
    wait_drained();

    set_max_den(32'd1);
    run_random_items(40, 1'b0);
    wait_drained();

    // upper bits dropped, leaving the largest limit
    set_max_den(32'hFFFF_FFFF);
    send_value(32'h0000_0001); send_value(32'h8000_0000);
    send_value(32'h0000_FFFF);
    run_random_items(40, 1'b1);
    wait_drained();

    // small random limits with junk in the upper bits
    repeat (6) begin
      data = $urandom;
      data[DEN_BITS-1:0] = DEN_BITS'($urandom_range(2, 400));
      set_max_den(data);
      run_random_items(60, 1'b0);
      wait_drained();
    end

    set_max_den(32'd1024);
    run_random_items(80, 1'b0);
    wait_drained();

    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_farey_rational_approximation_unit passed");
    end else begin
      $display("tb_farey_rational_approximation_unit failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/fra_pkg.sv
hw/rtl/fra_cfg.sv
hw/rtl/fra_dp.sv
hw/rtl/fra_ctrl.sv
hw/rtl/farey_rational_approximation_unit.sv
bench/fra_checker.sv
bench/tb_farey_rational_approximation_unit.sv
